// ===== src/scd_pkg.sv =====
// Package for the servo command deframer: codes, widths, CRC and clamp helpers.
`default_nettype none
package scd_pkg;

	localparam int BYTE_W  = 8;
	localparam int ANGLE_W = 16;
	localparam int CRC_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0]  START_BYTE = 8'hFF;
	localparam logic [CRC_W-1:0]   CRC_POLY   = 16'h1021;
	localparam logic [CRC_W-1:0]   CRC_INIT   = 16'hFFFF;
	localparam logic [BYTE_W-1:0]  CMD_SERVO  = 8'h00;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 2'd1;

	localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 16'd0;
	localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 16'd31416;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_BAD_ID  = 2'd2
	} status_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1])
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] raw,
			input logic [ANGLE_W-1:0] lo, input logic [ANGLE_W-1:0] hi);
		logic [ANGLE_W-1:0] v;
		v = (raw < hi) ? raw : hi;
		return (v > lo) ? v : lo;
	endfunction

endpackage
`default_nettype wire

// ===== src/servo_command_deframer.sv =====
// Servo command deframer top level: byte framing, running CRC, result register.
//
// Takes one received byte per transfer on the rx channel, at up to one byte
// every cycle. A frame is the start byte 0xFF, a command id, four big-endian
// 16-bit angles and a big-endian CRC-16/CCITT-FALSE over the nine payload
// bytes; 0xFF inside a frame is plain data. Each accepted byte is held in an
// input register, from which the frame state and CRC are updated unless a
// stalled result holds them; the last CRC byte loads the result register.
// Status 0 carries the four angles clamped to [min_angle, max_angle]
// (min_angle wins if the bounds cross); CRC mismatch (1) and unknown id (2)
// carry zero angles. The byte CRC update is combinational, which sets the
// one-byte-per-cycle rate; the input stalls only while a result waits
// stalled in the result register.
// Write min_angle/max_angle only while the block is idle.
`default_nettype none
module servo_command_deframer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rx_valid,
	output logic                               rx_stall,
	input  wire logic [scd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output scd_pkg::status_t                   frame_status,
	output logic [scd_pkg::ANGLE_W-1:0]        angle_ch0,
	output logic [scd_pkg::ANGLE_W-1:0]        angle_ch1,
	output logic [scd_pkg::ANGLE_W-1:0]        angle_ch2,
	output logic [scd_pkg::ANGLE_W-1:0]        angle_ch3,
	input  wire logic                          cfg_we,
	input  wire logic [scd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [scd_pkg::ANGLE_W-1:0]   cfg_data
);
	import scd_pkg::*;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_CRC     = 2'd2;
	localparam logic [3:0] LAST_PAYLOAD = 4'd8;

	logic [ANGLE_W-1:0] min_angle_q, max_angle_q;

	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [1:0]        phase_q;
	logic [3:0]        cnt_q;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] ang_q [8];
	logic [BYTE_W-1:0] crc_hi_q;

	logic              res_valid_q;
	status_t           status_q;
	logic [ANGLE_W-1:0] out_q [4];

	logic              proc, fire, emit;
	logic [CRC_W-1:0]  crc_next;
	logic [CRC_W-1:0]  rx_crc;
	status_t           status_d;
	logic [ANGLE_W-1:0] out_d [4];

	assign proc     = !(res_valid_q && res_stall);
	assign fire     = vld_s1 && proc;
	assign rx_stall = vld_s1 && !proc;
	assign emit     = fire && (phase_q == PH_CRC) && (cnt_q != 4'd0);
	assign crc_next = crc_feed(crc_q, byte_s1);
	assign rx_crc   = {crc_hi_q, byte_s1};

	always_comb begin
		if (rx_crc != crc_q)
			status_d = ST_CRC_ERR;
		else if (cmd_q != CMD_SERVO)
			status_d = ST_BAD_ID;
		else
			status_d = ST_OK;
		for (int j = 0; j < 4; j++) begin
			if (status_d == ST_OK)
				out_d[j] = clamp_angle({ang_q[2*j], ang_q[2*j+1]}, min_angle_q, max_angle_q);
			else
				out_d[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q <= MIN_ANGLE_RST;
			max_angle_q <= MAX_ANGLE_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_ANGLE)
				min_angle_q <= cfg_data;
			else if (cfg_index == REG_MAX_ANGLE)
				max_angle_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!rx_stall) begin
			vld_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall)
			byte_s1 <= rx_byte;
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			crc_q   <= CRC_INIT;
		end else if (fire) begin
			case (phase_q)
				PH_PAYLOAD: begin
					crc_q <= crc_next;
					if (cnt_q == LAST_PAYLOAD) begin
						phase_q <= PH_CRC;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				PH_CRC: begin
					if (cnt_q == 4'd0) begin
						cnt_q <= 4'd1;
					end else begin
						phase_q <= PH_IDLE;
						cnt_q   <= '0;
						crc_q   <= CRC_INIT;
					end
				end
				default: begin
					if (byte_s1 == START_BYTE) begin
						phase_q <= PH_PAYLOAD;
						cnt_q   <= '0;
						crc_q   <= CRC_INIT;
					end else begin
						phase_q <= PH_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire && phase_q == PH_PAYLOAD) begin
			if (cnt_q == 4'd0)
				cmd_q <= byte_s1;
			else
				ang_q[3'(cnt_q - 4'd1)] <= byte_s1;
		end
		if (fire && phase_q == PH_CRC && cnt_q == 4'd0)
			crc_hi_q <= byte_s1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= status_d;
			for (int j = 0; j < 4; j++)
				out_q[j] <= out_d[j];
		end
	end

	assign res_valid    = res_valid_q;
	assign frame_status = status_q;
	assign angle_ch0    = out_q[0];
	assign angle_ch1    = out_q[1];
	assign angle_ch2    = out_q[2];
	assign angle_ch3    = out_q[3];

	a_payload_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> cnt_q <= LAST_PAYLOAD)
		else $error("payload byte count overrun");

	a_idle_crc: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> crc_q == CRC_INIT)
		else $error("CRC not reset while idle");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> phase_q == PH_IDLE && res_valid_q)
		else $error("frame end did not return to idle with a result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q != ST_OK |->
		out_q[0] == '0 && out_q[1] == '0 && out_q[2] == '0 && out_q[3] == '0)
		else $error("rejected frame carries nonzero angles");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for servo_command_deframer: random framed byte traffic checked against a frame tracker.
`default_nettype none
module tb;
	import scd_pkg::*;

	localparam int PAYLOAD_BYTES  = 9;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_SET  = 258;
	localparam int NUM_SETS       = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		status_t                      status;
		logic [3:0][ANGLE_W-1:0]      ang;
	} servo_result_t;

	typedef enum logic [1:0] {
		SEEK_START,
		TAKE_PAYLOAD,
		TAKE_CRC
	} deframe_phase_t;

	class frame_tracker;
		logic [ANGLE_W-1:0] lo_bound;
		logic [ANGLE_W-1:0] hi_bound;
		deframe_phase_t     ph;
		int unsigned        pos;
		logic [CRC_W-1:0]   crc;
		logic [BYTE_W-1:0]  payload [PAYLOAD_BYTES];
		logic [BYTE_W-1:0]  crc_hi;
		servo_result_t      due_results [$];
		int unsigned        errors;

		function new();
			lo_bound = MIN_ANGLE_RST;
			hi_bound = MAX_ANGLE_RST;
			ph = SEEK_START;
			pos = 0;
			crc = CRC_INIT;
			crc_hi = '0;
			errors = 0;
			foreach (payload[i])
				payload[i] = '0;
		endfunction

		// bitwise form, MSB first
		static function logic [CRC_W-1:0] crc_ccitt_step(logic [CRC_W-1:0] c,
				logic [BYTE_W-1:0] b);
			logic fb;
			for (int i = BYTE_W - 1; i >= 0; i--) begin
				fb = c[CRC_W-1] ^ b[i];
				c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
			end
			return c;
		endfunction

		function logic [ANGLE_W-1:0] clip_angle(logic [ANGLE_W-1:0] raw);
			logic [ANGLE_W-1:0] v;
			v = (raw > hi_bound) ? hi_bound : raw;
			if (v < lo_bound)
				v = lo_bound;
			return v;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ANGLE_W-1:0] val);
			if (idx == REG_MIN_ANGLE)
				lo_bound = val;
			else if (idx == REG_MAX_ANGLE)
				hi_bound = val;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		// returns 0 for a byte the block ignores
		function bit take_byte(logic [BYTE_W-1:0] b);
			servo_result_t    res;
			logic [CRC_W-1:0] rx_crc;
			bit               used;
			used = 1'b1;
			case (ph)
				TAKE_PAYLOAD: begin
					crc = crc_ccitt_step(crc, b);
					payload[pos] = b;
					pos++;
					if (pos == PAYLOAD_BYTES) begin
						ph = TAKE_CRC;
						pos = 0;
					end
				end
				TAKE_CRC: begin
					if (pos == 0) begin
						crc_hi = b;
						pos = 1;
					end else begin
						rx_crc = {crc_hi, b};
						res = '0;
						if (rx_crc != crc)
							res.status = ST_CRC_ERR;
						else if (payload[0] != CMD_SERVO)
							res.status = ST_BAD_ID;
						else begin
							res.status = ST_OK;
							for (int j = 0; j < 4; j++)
								res.ang[j] = clip_angle({payload[1+2*j], payload[2+2*j]});
						end
						due_results.push_back(res);
						ph = SEEK_START;
						pos = 0;
					end
				end
				default: begin
					ph = SEEK_START;
					used = (b == START_BYTE);
					if (used) begin
						ph = TAKE_PAYLOAD;
						pos = 0;
						crc = CRC_INIT;
					end
				end
			endcase
			return used;
		endfunction

		task report_mismatch(string msg);
			if (errors < 100)
				$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_result(status_t st, logic [ANGLE_W-1:0] a0, logic [ANGLE_W-1:0] a1,
				logic [ANGLE_W-1:0] a2, logic [ANGLE_W-1:0] a3);
			servo_result_t           want;
			logic [3:0][ANGLE_W-1:0] got;
			got = {a3, a2, a1, a0};
			if (due_results.size() == 0) begin
				report_mismatch("result transfer with no frame pending");
				return;
			end
			want = due_results.pop_front();
			if (st !== want.status)
				report_mismatch($sformatf("frame_status %0d, want %0d", st, want.status));
			for (int j = 0; j < 4; j++)
				if (got[j] !== want.ang[j])
					report_mismatch($sformatf("angle_ch%0d %0d, want %0d (status %0d)",
						j, got[j], want.ang[j], want.status));
		endtask

		task finish_check();
			if (due_results.size() != 0)
				report_mismatch($sformatf("%0d frame results never arrived",
					due_results.size()));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 rx_valid = 1'b0;
	logic                 rx_stall;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	status_t              frame_status;
	logic [ANGLE_W-1:0]   angle_ch0;
	logic [ANGLE_W-1:0]   angle_ch1;
	logic [ANGLE_W-1:0]   angle_ch2;
	logic [ANGLE_W-1:0]   angle_ch3;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ANGLE_W-1:0]   cfg_data = '0;

	bit                   calm = 1'b0;
	bit                   hold_go = 1'b0;
	int unsigned          fed = 0;
	frame_tracker         sb = new();

	servo_command_deframer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.frame_status (frame_status),
		.angle_ch0    (angle_ch0),
		.angle_ch1    (angle_ch1),
		.angle_ch2    (angle_ch2),
		.angle_ch3    (angle_ch3),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res_stall <= !calm && ($urandom_range(99) < 20);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(frame_status, angle_ch0, angle_ch1, angle_ch2, angle_ch3);
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// called and returns at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!calm && $urandom_range(99) < 20) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		if (sb.take_byte(b))
			fed++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [ANGLE_W-1:0] a0,
			input logic [ANGLE_W-1:0] a1, input logic [ANGLE_W-1:0] a2,
			input logic [ANGLE_W-1:0] a3, input bit crc_ok);
		logic [BYTE_W-1:0] fb [12];
		logic [CRC_W-1:0]  c;
		fb[0] = START_BYTE;
		fb[1] = id;
		{fb[2], fb[3]} = a0;
		{fb[4], fb[5]} = a1;
		{fb[6], fb[7]} = a2;
		{fb[8], fb[9]} = a3;
		c = CRC_INIT;
		for (int i = 1; i <= PAYLOAD_BYTES; i++)
			c = frame_tracker::crc_ccitt_step(c, fb[i]);
		if (!crc_ok)
			c ^= 16'd1 << $urandom_range(15);
		{fb[10], fb[11]} = c;
		for (int i = 0; i < 12; i++)
			send_byte(fb[i]);
	endtask

	function automatic logic [ANGLE_W-1:0] pick_angle();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return sb.lo_bound;
			3: return sb.hi_bound;
			4: return sb.lo_bound - 16'd1;
			5: return sb.hi_bound + 16'd1;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic random_traffic();
		int unsigned       pick;
		int unsigned       n;
		logic [BYTE_W-1:0] id;
		pick = $urandom_range(99);
		if (pick < 80) begin
			id = ($urandom_range(99) < 80) ? CMD_SERVO : 8'($urandom_range(1, 255));
			send_frame(id, pick_angle(), pick_angle(), pick_angle(), pick_angle(),
				$urandom_range(99) < 85);
		end else if (pick < 90) begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(8'($urandom_range(254)));
		end else begin
			// broken run: may start a frame anywhere
			n = $urandom_range(1, 12);
			repeat (n) send_byte(8'($urandom));
		end
	endtask

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [ANGLE_W-1:0] v;
		int unsigned        target;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// idle junk, a good frame with 0xFF data inside, a bad CRC on an unknown id
		send_byte(8'h7E);
		send_frame(CMD_SERVO, 16'hFFFF, 16'h0000, MAX_ANGLE_RST, 16'h7FFF, 1'b1);
		send_frame(8'h5A, 16'h1234, 16'h00FF, 16'hFF00, 16'h8001, 1'b0);

		for (int s = 0; s < NUM_SETS; s++) begin
			if (s > 0) begin
				drain();
				case (s)
					1: begin
						write_reg(REG_MIN_ANGLE, '0);
						write_reg(REG_MAX_ANGLE, '1);
					end
					2: begin
						// crossed bounds
						write_reg(REG_MIN_ANGLE, '1);
						write_reg(REG_MAX_ANGLE, '0);
					end
					3: begin
						write_reg(REG_MIN_ANGLE, 16'd1000);
						write_reg(REG_MAX_ANGLE, 16'd2000);
					end
					4: begin
						write_reg(REG_MIN_ANGLE, 16'($urandom));
						write_reg(REG_MAX_ANGLE, 16'($urandom));
						write_reg(REG_SPARE_A, 16'($urandom));
						write_reg(REG_SPARE_B, 16'($urandom));
					end
					default: begin
						v = 16'($urandom);
						write_reg(REG_MIN_ANGLE, v);
						write_reg(REG_MAX_ANGLE, v);
					end
				endcase
				cfg_we <= 1'b0;
			end
			calm = (s == 2);
			if (s == 3)
				hold_go = 1'b1;
			target = fed + ITEMS_PER_SET;
			while (fed < target)
				random_traffic();
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		sb.finish_check();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
src/scd_pkg.sv
src/servo_command_deframer.sv
tb/tb.sv
